// ----- rtl/x86_page_table_walker_assert.svh -----
// Assertion helpers for the walker RTL.
`ifndef X86_PAGE_TABLE_WALKER_ASSERT_SVH
`define X86_PAGE_TABLE_WALKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define XPTW_ASSERT(lbl, prp, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prp) else $error(msg);

// Check a property on every clock edge, reset included.
`define XPTW_ASSERT_ALWAYS(lbl, prp, msg) \
   lbl: assert property (@(posedge clock) prp) else $error(msg);

`endif

// ----- rtl/xptw_pkg.sv -----
// ----------------------------------------------------------------------------
// xptw_pkg
// Types and constants shared by the page table walker modules.
// ----------------------------------------------------------------------------
`default_nettype none
package xptw_pkg;

   localparam int PHYS_ADDR_BITS = 48;
   localparam int NONPAE_ENTRIES = 1024;
   localparam int PAE_ENTRIES    = 512;
   localparam int PDP_ENTRIES    = 4;

   localparam logic [47:0] PHYS_MASK48 = (PHYS_ADDR_BITS >= 48) ? {48{1'b1}} :
      48'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
   localparam logic [47:0] NP_MASK_4K  = 48'h0000_ffff_f000;
   localparam logic [47:0] NP_MASK_4M  = 48'h0000_ffc0_0000;
   localparam logic [47:0] PAE_MASK_4K = 48'hffff_ffff_f000;
   localparam logic [47:0] PAE_MASK_2M = 48'hffff_ffe0_0000;
   localparam logic [63:0] KERNEL_BASE = 64'hffff_0000_0000_0000;
   localparam int PRESENT_BIT = 0;
   localparam int LARGE_BIT   = 7;

   localparam logic OP_START    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   localparam logic CSR_ROOT = 1'b0;
   localparam logic CSR_PAE  = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_PAGE  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_4M = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [47:0] pa;
      logic [63:0] va;
      logic [1:0]  size;
      logic        last;
   } result_type;

   // One accepted item's results: r0 only when two is set, r1 always.
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } bundle_type;

endpackage
`default_nettype wire

// ----- rtl/xptw_req_if.sv -----
// ----------------------------------------------------------------------------
// xptw_req_if
// Input channel: start commands and table entry read responses.
// ----------------------------------------------------------------------------
`default_nettype none
interface xptw_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [63:0] entry_word;
   logic        read_failed;
   modport source (output valid, opcode, entry_word, read_failed, input ready);
   modport sink   (input valid, opcode, entry_word, read_failed, output ready);
endinterface
`default_nettype wire

// ----- rtl/xptw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// xptw_rsp_if
// Result channel: read requests, mapped pages, done and error reports.
// ----------------------------------------------------------------------------
`default_nettype none
interface xptw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [47:0] physical_address;
   logic [63:0] virtual_address;
   logic [1:0]  page_size_code;
   logic        last_of_run;
   modport source (output valid, result_kind, physical_address, virtual_address,
                   page_size_code, last_of_run, input ready);
   modport sink   (input valid, result_kind, physical_address, virtual_address,
                   page_size_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/x86_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// x86_page_table_walker
// Depth-first walker over two-level or PAE three-level x86 page tables.
// ----------------------------------------------------------------------------
// An accepted transaction's first result passes through a queue slot and then the output register.
// Throughput: one input transaction per cycle while the queue has room.
// Results leave at one per cycle while the receiver takes them; a mapped page and its next request leave as two.
// The output register alone sets the result rate.
// Reset (synchronous) idles the walk, clears the control registers and empties the queue; bases and slots keep data.
`default_nettype none
module x86_page_table_walker
   import xptw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_wdata,
   xptw_req_if.sink         req_ch,
   xptw_rsp_if.source       rsp_ch
);

   // Front to queue: one bundle per item that makes results.
   logic       push, space;
   bundle_type push_data;
   // Queue to back.
   logic       head_valid, pop;
   bundle_type head_data;

   // Front: walk state, config registers, result build.
   xptw_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_ch, .space, .push, .push_data
   );

   // Decouple front and back so each side stalls on its own.
   xptw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_data, .space,
      .head_valid, .head_data, .pop
   );

   // Back: split bundles and hold each result until taken.
   xptw_back u_back (
      .clock, .reset, .head_valid, .head_data, .pop, .rsp_ch
   );

endmodule
`default_nettype wire

// ----- rtl/xptw_front.sv -----
// ----------------------------------------------------------------------------
// xptw_front
// Accept items, step the walk state and build the results of each item.
// ----------------------------------------------------------------------------
`default_nettype none
module xptw_front
   import xptw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_wdata,
   xptw_req_if.sink         req_ch,
   input  wire logic        space,
   output      logic        push,
   output      bundle_type  push_data
);

   logic [47:0] root_ff, root_in;
   logic        pae_ff, pae_in;
   logic        active_ff, active_in;
   logic [1:0]  level_ff, level_in;
   logic [47:0] base_ff [3];
   logic [47:0] base_in [3];
   logic [9:0]  index_ff [3];
   logic [9:0]  index_in [3];

   logic        accept;
   logic [63:0] e;
   logic [1:0]  last_lvl, lvl, tgt;
   logic        big_page, leaf, found;
   logic [10:0] nxt [3];
   logic [2:0]  fits;
   logic [63:0] vbase;
   logic [47:0] leaf_pa, next_base, req_addr;
   logic [1:0]  leaf_size;
   result_type  res_pop;

   assign req_ch.ready = space;
   assign accept = req_ch.valid && space;

   function automatic logic [5:0] shift_of(input logic pae, input logic [1:0] k);
      logic [5:0] s;
      if (pae) s = (k == 2'd0) ? 6'd30 : ((k == 2'd1) ? 6'd21 : 6'd12);
      else     s = (k == 2'd0) ? 6'd22 : 6'd12;
      return s;
   endfunction

   always_comb begin
      root_in = root_ff;
      pae_in  = pae_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROOT: root_in = csr_wdata;
            CSR_PAE:  pae_in  = csr_wdata[0];
            default:  root_in = root_ff;
         endcase
      end
   end

   always_comb begin
      active_in = active_ff;
      level_in  = level_ff;
      for (int k = 0; k < 3; k++) begin
         base_in[k]  = base_ff[k];
         index_in[k] = index_ff[k];
      end
      push      = 1'b0;
      push_data = '0;

      e        = pae_ff ? req_ch.entry_word : {32'd0, req_ch.entry_word[31:0]};
      last_lvl = pae_ff ? 2'd2 : 2'd1;
      lvl      = (level_ff > last_lvl) ? last_lvl : level_ff;
      big_page = e[LARGE_BIT] && (lvl == last_lvl - 2'd1);
      leaf     = (lvl == last_lvl) || big_page;

      if (lvl == last_lvl) begin
         leaf_pa   = e[47:0] & (pae_ff ? PAE_MASK_4K : NP_MASK_4K);
         leaf_size = SIZE_4K;
      end else if (pae_ff) begin
         leaf_pa   = e[47:0] & PAE_MASK_2M;
         leaf_size = SIZE_2M;
      end else begin
         leaf_pa   = e[47:0] & NP_MASK_4M;
         leaf_size = SIZE_4M;
      end
      leaf_pa   = leaf_pa & PHYS_MASK48;
      next_base = e[47:0] & (pae_ff ? PAE_MASK_4K : NP_MASK_4K) & PHYS_MASK48;

      vbase = '0;
      for (int k = 0; k < 3; k++) begin
         if (2'(k) <= lvl) vbase = vbase | ({54'd0, index_ff[k]} << shift_of(pae_ff, 2'(k)));
      end

      // Pop: nearest level at or above lvl that still has entries left.
      for (int k = 0; k < 3; k++) begin
         nxt[k] = {1'b0, index_ff[k]} + 11'd1;
         if (pae_ff) fits[k] = (k == 0) ? (nxt[k] < 11'(PDP_ENTRIES)) :
                                          (nxt[k] < 11'(PAE_ENTRIES));
         else        fits[k] = nxt[k] < 11'(NONPAE_ENTRIES);
      end
      found = 1'b0;
      tgt   = 2'd0;
      for (int k = 2; k >= 0; k--) begin
         if (!found && 2'(k) <= lvl && fits[k]) begin
            found = 1'b1;
            tgt   = 2'(k);
         end
      end
      req_addr = (base_ff[tgt] + (pae_ff ? {35'd0, nxt[tgt][9:0], 3'd0} :
                                           {36'd0, nxt[tgt][9:0], 2'd0})) & PHYS_MASK48;
      res_pop = '0;
      res_pop.last = 1'b1;
      if (found) begin
         res_pop.kind = KIND_READ;
         res_pop.pa   = req_addr;
      end else begin
         res_pop.kind = KIND_DONE;
      end

      if (accept) begin
         if (req_ch.opcode == OP_START) begin
            active_in = 1'b1;
            level_in  = 2'd0;
            for (int k = 0; k < 3; k++) index_in[k] = '0;
            base_in[0]        = root_ff;
            push              = 1'b1;
            push_data.r1.kind = KIND_READ;
            push_data.r1.pa   = root_ff & PHYS_MASK48;
            push_data.r1.last = 1'b1;
         end else if (active_ff) begin
            push              = 1'b1;
            push_data.r1.last = 1'b1;
            if (req_ch.read_failed) begin
               active_in         = 1'b0;
               push_data.r1.kind = KIND_ERROR;
            end else if (e[PRESENT_BIT] && !leaf) begin
               // Descend into the next table.
               base_in[lvl + 2'd1]  = next_base;
               index_in[lvl + 2'd1] = '0;
               level_in             = lvl + 2'd1;
               push_data.r1.kind    = KIND_READ;
               push_data.r1.pa      = next_base;
            end else begin
               if (e[PRESENT_BIT]) begin
                  push_data.two     = 1'b1;
                  push_data.r0.kind = KIND_PAGE;
                  push_data.r0.pa   = leaf_pa;
                  push_data.r0.va   = vbase | KERNEL_BASE;
                  push_data.r0.size = leaf_size;
                  push_data.r0.last = 1'b0;
               end
               push_data.r1 = res_pop;
               if (found) begin
                  index_in[tgt] = nxt[tgt][9:0];
                  level_in      = tgt;
               end else begin
                  active_in = 1'b0;
                  level_in  = 2'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff   <= '0;
         pae_ff    <= 1'b0;
         active_ff <= 1'b0;
         level_ff  <= '0;
         for (int k = 0; k < 3; k++) index_ff[k] <= '0;
      end else begin
         root_ff   <= root_in;
         pae_ff    <= pae_in;
         active_ff <= active_in;
         level_ff  <= level_in;
         for (int k = 0; k < 3; k++) index_ff[k] <= index_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) base_ff[k] <= base_in[k];
   end

endmodule
`default_nettype wire

// ----- rtl/xptw_queue.sv -----
// ----------------------------------------------------------------------------
// xptw_queue
// Short queue of per-item result bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "x86_page_table_walker_assert.svh"
module xptw_queue
   import xptw_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   output      logic       space,
   output      logic       head_valid,
   output      bundle_type head_data,
   input  wire logic       pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type      slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign space      = count_ff != CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ff];
   assign do_push    = push && space;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   `XPTW_ASSERT_ALWAYS(a_reset_empty, reset |=> count_ff == '0, "queue not empty after reset")
   `XPTW_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "queue count past depth")
   `XPTW_ASSERT(a_count_track, (do_push && !do_pop) |=> count_ff == $past(count_ff) + CW'(1), "lost push")

endmodule
`default_nettype wire

// ----- rtl/xptw_back.sv -----
// ----------------------------------------------------------------------------
// xptw_back
// Drain result bundles one result per cycle, while the receiver takes them, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module xptw_back
   import xptw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire bundle_type head_data,
   output      logic       pop,
   xptw_rsp_if.source      rsp_ch
);

   logic       valid_ff, valid_in;
   logic       sub_ff, sub_in;
   result_type out_ff, out_in;
   logic       load, first;

   assign load  = head_valid && (!valid_ff || rsp_ch.ready);
   assign first = head_data.two && !sub_ff;
   assign pop   = load && !first;

   always_comb begin
      valid_in = valid_ff && !rsp_ch.ready;
      sub_in   = sub_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in = 1'b1;
         out_in   = first ? head_data.r0 : head_data.r1;
         sub_in   = first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.result_kind      = out_ff.kind;
   assign rsp_ch.physical_address = out_ff.pa;
   assign rsp_ch.virtual_address  = out_ff.va;
   assign rsp_ch.page_size_code   = out_ff.size;
   assign rsp_ch.last_of_run      = out_ff.last;

endmodule
`default_nettype wire
